// ===== rtl/pfnc_pkg.sv =====
// ----------------------------------------------------------------------------
// Portable file name checker package
// Character codes, default limits and helper functions for the checker.
// ----------------------------------------------------------------------------
package pfnc_pkg;

   localparam int MAX_BYTES_DEFAULT = 255;
   localparam int BASE_DEPTH = 6;
   localparam int BASE_LEN_WIDTH = 3;

   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_LESS      = 8'h3C;
   localparam logic [7:0] CHAR_GREATER   = 8'h3E;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_PIPE      = 8'h7C;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;
   localparam logic [7:0] CHAR_ONE       = 8'h31;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   localparam logic [23:0] WORD_CON = "CON";
   localparam logic [23:0] WORD_PRN = "PRN";
   localparam logic [23:0] WORD_AUX = "AUX";
   localparam logic [23:0] WORD_NUL = "NUL";
   localparam logic [23:0] WORD_COM = "COM";
   localparam logic [23:0] WORD_LPT = "LPT";
   localparam logic [47:0] WORD_CLOCK = "CLOCK$";

   typedef enum logic [2:0] {
      CONT_ANY    = 3'd0,
      CONT_A0_BF  = 3'd1,
      CONT_80_9F  = 3'd2,
      CONT_90_BF  = 3'd3,
      CONT_80_8F  = 3'd4
   } cont_class_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic forbidden_ascii(input logic [7:0] b);
      return (b < 8'h20) || (b == CHAR_DEL) || (b == CHAR_SLASH) ||
             (b == CHAR_BACKSLASH) || (b == CHAR_COLON) || (b == CHAR_LESS) ||
             (b == CHAR_GREATER) || (b == CHAR_QUOTE) || (b == CHAR_PIPE) ||
             (b == CHAR_QUESTION) || (b == CHAR_STAR);
   endfunction

endpackage

// ===== rtl/portable_file_name_checker_top.sv =====
// ----------------------------------------------------------------------------
// Portable file name checker
// Checks a file name streamed one byte per word and returns one pass flag.
// The result word is registered, in the skid entry if the output register is held.
// Throughput: one byte per cycle unless stalled; per-byte update in one pass.
// A two-entry output stage (register plus skid) stalls the input only while
// both entries hold result words.
// Reset is synchronous, active high, and drops any name in progress.
// ----------------------------------------------------------------------------
module portable_file_name_checker_top
   import pfnc_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_flag,
   input  logic       req_empty_name,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_name_valid
);

   localparam int CountWidth = $clog2(MAX_BYTES + 2);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_BYTES);

   logic [CountWidth-1:0]     byte_count_ff, byte_count_in;
   logic [1:0]                cont_left_ff, cont_left_in;
   cont_class_type            cont_class_ff, cont_class_in;
   logic                      lead_c2_ff, lead_c2_in;
   logic [7:0]                base_prefix_ff [BASE_DEPTH];
   logic [7:0]                base_prefix_in [BASE_DEPTH];
   logic [BASE_LEN_WIDTH-1:0] base_len_ff, base_len_in;
   logic                      dot_seen_ff, dot_seen_in;
   logic                      failed_ff, failed_in;

   logic rsp_valid_ff, rsp_data_ff;
   logic skid_valid_ff, skid_data_ff;

   logic fire_in, gen_result, out_free, result_value, reserved, bad_cont;
   logic [7:0] b, lo, hi;

   assign req_stall = skid_valid_ff;
   assign fire_in = req_valid && !req_stall;
   assign gen_result = fire_in && (req_final_flag || req_empty_name);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_name_valid = rsp_data_ff;
   assign b = req_data_byte;

   always_comb begin
      byte_count_in = byte_count_ff;
      cont_left_in = cont_left_ff;
      cont_class_in = cont_class_ff;
      lead_c2_in = lead_c2_ff;
      base_prefix_in = base_prefix_ff;
      base_len_in = base_len_ff;
      dot_seen_in = dot_seen_ff;
      failed_in = failed_ff;
      lo = 8'h80;
      hi = 8'hBF;
      bad_cont = 1'b0;

      if (byte_count_ff <= CountMax) begin
         byte_count_in = byte_count_ff + 1'b1;
      end

      case (cont_class_ff)
         CONT_A0_BF: lo = 8'hA0;
         CONT_80_9F: hi = 8'h9F;
         CONT_90_BF: lo = 8'h90;
         CONT_80_8F: hi = 8'h8F;
         default: ;
      endcase

      if (cont_left_ff != 2'd0) begin
         bad_cont = (b < lo) || (b > hi) || (lead_c2_ff && b <= 8'h9F);
         if (bad_cont) begin
            failed_in = 1'b1;
            cont_left_in = 2'd0;
         end else begin
            cont_left_in = cont_left_ff - 2'd1;
         end
         cont_class_in = CONT_ANY;
         lead_c2_in = 1'b0;
      end else if (b < 8'h80) begin
         if (forbidden_ascii(b)) begin
            failed_in = 1'b1;
         end
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         cont_left_in = 2'd1;
         cont_class_in = CONT_ANY;
         lead_c2_in = (b == 8'hC2);
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         cont_left_in = 2'd2;
         cont_class_in = (b == 8'hE0) ? CONT_A0_BF :
                         ((b == 8'hED) ? CONT_80_9F : CONT_ANY);
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         cont_left_in = 2'd3;
         cont_class_in = (b == 8'hF0) ? CONT_90_BF :
                         ((b == 8'hF4) ? CONT_80_8F : CONT_ANY);
      end else begin
         failed_in = 1'b1;
      end

      if (!dot_seen_ff) begin
         if (b == CHAR_DOT) begin
            dot_seen_in = 1'b1;
         end else begin
            for (int i = 0; i < BASE_DEPTH; i++) begin
               if (base_len_ff == BASE_LEN_WIDTH'(i)) begin
                  base_prefix_in[i] = b;
               end
            end
            if (base_len_ff != {BASE_LEN_WIDTH{1'b1}}) begin
               base_len_in = base_len_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [23:0] w3;
      logic [47:0] w6;
      w3 = {fold_upper(base_prefix_in[0]), fold_upper(base_prefix_in[1]),
            fold_upper(base_prefix_in[2])};
      w6 = {w3, fold_upper(base_prefix_in[3]), fold_upper(base_prefix_in[4]),
            fold_upper(base_prefix_in[5])};
      case (base_len_in)
         3'd3: reserved = (w3 == WORD_CON) || (w3 == WORD_PRN) ||
                          (w3 == WORD_AUX) || (w3 == WORD_NUL);
         3'd4: reserved = ((w3 == WORD_COM) || (w3 == WORD_LPT)) &&
                          (base_prefix_in[3] >= CHAR_ONE) &&
                          (base_prefix_in[3] <= CHAR_NINE);
         3'd6: reserved = (w6 == WORD_CLOCK);
         default: reserved = 1'b0;
      endcase
      result_value = !req_empty_name && !failed_in &&
                     (byte_count_in <= CountMax) && (cont_left_in == 2'd0) &&
                     (b != CHAR_DOT) && (b != CHAR_SPACE) && !reserved;
   end

   always_ff @(posedge clock) begin
      if (reset || gen_result) begin
         byte_count_ff <= '0;
         cont_left_ff <= 2'd0;
         cont_class_ff <= CONT_ANY;
         lead_c2_ff <= 1'b0;
         base_len_ff <= '0;
         dot_seen_ff <= 1'b0;
         failed_ff <= 1'b0;
      end else if (fire_in) begin
         byte_count_ff <= byte_count_in;
         cont_left_ff <= cont_left_in;
         cont_class_ff <= cont_class_in;
         lead_c2_ff <= lead_c2_in;
         base_len_ff <= base_len_in;
         dot_seen_ff <= dot_seen_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_in) begin
         base_prefix_ff <= base_prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= gen_result;
         end
      end else if (gen_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : result_value;
      end else if (gen_result) begin
         skid_data_ff <= result_value;
      end
   end

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("Skid entry held while the output register is empty.");

   a_empty_gives_fail: assert property (@(posedge clock) disable iff (reset)
      (fire_in && req_empty_name && out_free && !skid_valid_ff)
      |=> (rsp_valid && !rsp_name_valid))
      else $error("Empty name did not produce a failing result word.");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      gen_result |=> (byte_count_ff == '0 && cont_left_ff == 2'd0 && !failed_ff))
      else $error("Per-name state not cleared after a result word.");

endmodule
